FILE: rtl/jsfp_pkg.sv
`default_nettype none
package jsfp_pkg;

  localparam int AxisW    = 8;
  localparam int PosW     = 16;
  localparam int MagW     = 9;
  localparam int DirW     = 9;
  localparam int DzW      = 15;
  localparam int GainW    = 8;
  localparam int LevelW   = 17;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  localparam int ForceW   = 23;
  localparam int SqW      = 2 * ForceW;
  localparam int NormW    = SqW + 1;
  localparam int NormShr  = 30;
  localparam int NormHiW  = NormW - NormShr;
  localparam int RootBitW = 4;
  localparam int FracW    = 16;
  localparam int CordW    = ForceW + FracW + 3;
  localparam int AngW     = 24;
  localparam int StepW    = 5;
  localparam int CordSteps = 20;
  localparam int DegW     = 7;

  localparam logic [DzW-1:0]   DeadZoneRst = DzW'(8000);
  localparam logic [GainW-1:0] GainRst     = GainW'(10);
  localparam logic [DegW-1:0]  DegCap      = DegW'(90);
  localparam logic [AngW-1:0]  AngCap      = AngW'(90) << FracW;

  localparam logic [DirW:0] DirNorth = (DirW + 1)'(0);
  localparam logic [DirW:0] DirEast  = (DirW + 1)'(90);
  localparam logic [DirW:0] DirSouth = (DirW + 1)'(180);
  localparam logic [DirW:0] DirWest  = (DirW + 1)'(270);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEAD_ZONE = 8'd0,
    REG_GAIN_X    = 8'd1,
    REG_GAIN_Y    = 8'd2
  } cfg_reg_e;

  function automatic logic [AngW-1:0] atan_lut(input logic [StepW-1:0] step);
    logic [AngW-1:0] v;
    case (step)
      5'd0:    v = AngW'(2949207);
      5'd1:    v = AngW'(1741019);
      5'd2:    v = AngW'(919906);
      5'd3:    v = AngW'(466959);
      5'd4:    v = AngW'(234386);
      5'd5:    v = AngW'(117307);
      5'd6:    v = AngW'(58668);
      5'd7:    v = AngW'(29336);
      5'd8:    v = AngW'(14668);
      5'd9:    v = AngW'(7334);
      5'd10:   v = AngW'(3667);
      5'd11:   v = AngW'(1834);
      5'd12:   v = AngW'(917);
      5'd13:   v = AngW'(458);
      5'd14:   v = AngW'(229);
      5'd15:   v = AngW'(115);
      5'd16:   v = AngW'(57);
      5'd17:   v = AngW'(29);
      5'd18:   v = AngW'(14);
      5'd19:   v = AngW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/jsfp_if.sv
`default_nettype none
interface jsfp_evt_if;
  import jsfp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [AxisW-1:0]       axis;
  logic signed [PosW-1:0] position;
  modport source (output valid, output axis, output position, input ready);
  modport sink   (input valid, input axis, input position, output ready);
endinterface

interface jsfp_res_if;
  import jsfp_pkg::*;
  logic            valid;
  logic            ready;
  logic [MagW-1:0] magnitude;
  logic [DirW-1:0] direction;
  modport source (output valid, output magnitude, output direction, input ready);
  modport sink   (input valid, input magnitude, input direction, output ready);
endinterface

interface jsfp_cfg_if;
  import jsfp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/joystick_spring_force_polar.sv
// channel | dir | transaction
// evt_i   | in  | axis, position
// res_o   | out | magnitude, direction
// cfg_i   | in  | index, data (dead_zone, gain_x, gain_y)
//
// an event with no active axis gives no result
// otherwise two gain products and two squares on the shared multiplier, 9 root bits and a finish step,
// plus up to 20 rotations of the shared shift-add stage when both axes are active and both gains are nonzero
// evt_i takes a new event while a finished result still waits on res_o
// asynchronous active-low reset; cfg_i is always ready
`default_nettype none
module joystick_spring_force_polar (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsfp_evt_if.sink    evt_i,
  jsfp_res_if.source  res_o,
  jsfp_cfg_if.sink    cfg_i
);
  import jsfp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FX,
    ST_MUL_FY,
    ST_SQ_FX,
    ST_SQ_FY,
    ST_SQRT,
    ST_CORDIC,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [DzW-1:0]   dz_q;
  logic [GainW-1:0] gain_x_q, gain_y_q;

  logic              x_act_q, x_neg_q, y_act_q, y_neg_q;
  logic [LevelW-1:0] x_mag_q, y_mag_q;

  logic [ForceW-1:0]      fx_q, fy_q;
  logic [NormW-1:0]       n_q;
  logic [MagW-1:0]        m_q;
  logic [RootBitW-1:0]    bit_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic signed [AngW-1:0]  z_q;
  logic [StepW-1:0]       i_q;

  logic            res_valid_q;
  logic [MagW-1:0] res_mag_q;
  logic [DirW-1:0] res_dir_q;
  logic            res_load;

  // event decode
  logic signed [LevelW-1:0] pos_ext, dz_ext;
  logic                     pos_low, pos_high, pos_act;
  logic [LevelW-1:0]        pos_mag;
  logic                     evt_acc, x_act_n, y_act_n;

  assign pos_ext  = LevelW'(evt_i.position);
  assign dz_ext   = signed'({2'b00, dz_q});
  assign pos_low  = pos_ext < -dz_ext;
  assign pos_high = pos_ext > dz_ext;
  assign pos_act  = pos_low | pos_high;
  assign pos_mag  = pos_act ? (pos_low ? LevelW'(-pos_ext) : LevelW'(pos_ext)) : '0;

  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_acc     = evt_i.valid & evt_i.ready;
  assign x_act_n     = (evt_i.axis == AxisW'(0)) ? pos_act : x_act_q;
  assign y_act_n     = (evt_i.axis == AxisW'(1)) ? pos_act : y_act_q;

  // shared multiplier
  logic [ForceW-1:0] mul_a, mul_b;
  logic [SqW-1:0]    mul_p;
  logic [MagW-1:0]   root_cand;

  assign root_cand = m_q | (MagW'(1) << bit_q);
  assign mul_p     = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL_FX: begin
        mul_a = ForceW'(gain_x_q);
        mul_b = ForceW'(x_mag_q);
      end
      ST_MUL_FY: begin
        mul_a = ForceW'(gain_y_q);
        mul_b = ForceW'(y_mag_q);
      end
      ST_SQ_FX: begin
        mul_a = fx_q;
        mul_b = fx_q;
      end
      ST_SQ_FY: begin
        mul_a = fy_q;
        mul_b = fy_q;
      end
      ST_SQRT: begin
        mul_a = ForceW'(root_cand);
        mul_b = ForceW'(root_cand);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic root_fit;
  assign root_fit = mul_p <= SqW'(n_q[NormW-1 -: NormHiW]);

  // shared shift-add rotation stage
  logic [CordW-1:0]        cy_abs, sy_mag;
  logic signed [CordW-1:0] sy, sx;
  logic [AngW-1:0]         step_ang;

  assign cy_abs   = cy_q[CordW-1] ? CordW'(-cy_q) : CordW'(cy_q);
  assign sy_mag   = cy_abs >> i_q;
  assign sy       = cy_q[CordW-1] ? -signed'(sy_mag) : signed'(sy_mag);
  assign sx       = signed'(CordW'(cx_q) >> i_q);
  assign step_ang = atan_lut(i_q);

  // direction
  logic [DegW-1:0] t_abs;
  logic [7:0]      z_int;
  logic [DirW:0]   dir_base, dir_sum;

  assign z_int = z_q[FracW +: 8];

  always_comb begin
    if (z_q <= 0) begin
      t_abs = '0;
    end else if (z_int > 8'(DegCap)) begin
      t_abs = DegCap;
    end else begin
      t_abs = z_int[DegW-1:0];
    end
    dir_base = x_neg_q ? DirWest : DirEast;
    if (!x_act_q) begin
      dir_sum = y_neg_q ? DirSouth : DirNorth;
    end else if (!y_act_q) begin
      dir_sum = dir_base;
    end else if (x_neg_q ^ y_neg_q) begin
      dir_sum = dir_base + (DirW + 1)'(t_abs);
    end else begin
      dir_sum = dir_base - (DirW + 1)'(t_abs);
    end
  end

  assign res_load        = (state_q == ST_FIN) && (!res_valid_q || res_o.ready);
  assign cfg_i.ready     = 1'b1;
  assign res_o.valid     = res_valid_q;
  assign res_o.magnitude = res_mag_q;
  assign res_o.direction = res_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q     <= DeadZoneRst;
      gain_x_q <= GainRst;
      gain_y_q <= GainRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEAD_ZONE: dz_q     <= cfg_i.data[DzW-1:0];
        REG_GAIN_X:    gain_x_q <= cfg_i.data[GainW-1:0];
        REG_GAIN_Y:    gain_y_q <= cfg_i.data[GainW-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_act_q     <= 1'b0;
      x_neg_q     <= 1'b0;
      y_act_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      x_mag_q     <= '0;
      y_mag_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
        res_mag_q   <= m_q;
        res_dir_q   <= dir_sum[DirW-1:0];
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (evt_acc) begin
            if (evt_i.axis == AxisW'(0)) begin
              x_act_q <= pos_act;
              x_neg_q <= pos_low;
              x_mag_q <= pos_mag;
            end else if (evt_i.axis == AxisW'(1)) begin
              y_act_q <= pos_act;
              y_neg_q <= pos_high;
              y_mag_q <= pos_mag;
            end
            if (x_act_n || y_act_n) begin
              state_q <= ST_MUL_FX;
            end
          end
        end
        ST_MUL_FX: begin
          fx_q    <= mul_p[ForceW-1:0];
          state_q <= ST_MUL_FY;
        end
        ST_MUL_FY: begin
          fy_q    <= mul_p[ForceW-1:0];
          state_q <= ST_SQ_FX;
        end
        ST_SQ_FX: begin
          n_q     <= NormW'(mul_p);
          state_q <= ST_SQ_FY;
        end
        ST_SQ_FY: begin
          n_q     <= n_q + NormW'(mul_p);
          m_q     <= '0;
          bit_q   <= RootBitW'(MagW - 1);
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (root_fit) begin
            m_q <= root_cand;
          end
          if (bit_q != '0) begin
            bit_q <= bit_q - RootBitW'(1);
          end else if (x_act_q && y_act_q && gain_x_q != '0 && gain_y_q != '0) begin
            cx_q    <= signed'(CordW'(fx_q) << FracW);
            cy_q    <= signed'(CordW'(fy_q) << FracW);
            z_q     <= '0;
            i_q     <= '0;
            state_q <= ST_CORDIC;
          end else begin
            z_q     <= (gain_y_q == '0) ? '0 : signed'(AngCap);
            state_q <= ST_FIN;
          end
        end
        ST_CORDIC: begin
          if (cy_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            if (!cy_q[CordW-1]) begin
              cx_q <= cx_q + sy;
              cy_q <= cy_q - sx;
              z_q  <= z_q + signed'(step_ang);
            end else begin
              cx_q <= cx_q - sy;
              cy_q <= cy_q + sx;
              z_q  <= z_q - signed'(step_ang);
            end
            i_q <= i_q + StepW'(1);
            if (i_q == StepW'(CordSteps - 1)) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (res_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/jsfp_checker.sv
`default_nettype none
module jsfp_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  evt_ready_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic [jsfp_pkg::MagW-1:0] res_magnitude_i,
  input logic [jsfp_pkg::DirW-1:0] res_direction_i
);
  import jsfp_pkg::*;

  // result stays offered until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before transaction");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_magnitude_i) && $stable(res_direction_i))
    else $error("stalled result changed");

  // a new result comes out of a busy cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!evt_ready_i))
    else $error("result raised while idle");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_direction_i <= DirW'(360))
    else $error("direction out of range");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_magnitude_i <= MagW'(361))
    else $error("magnitude out of range");

endmodule

bind joystick_spring_force_polar jsfp_checker u_jsfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .evt_ready_i    (evt_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_magnitude_i(res_o.magnitude),
  .res_direction_i(res_o.direction)
);
`default_nettype wire

FILE: tb/joystick_spring_force_polar_tb.sv
module joystick_spring_force_polar_tb;
  import jsfp_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 40;
  localparam logic [AxisW-1:0] AxisX = 8'd0;
  localparam logic [AxisW-1:0] AxisY = 8'd1;
  localparam logic [AxisW-1:0] AxisSpare = 8'd7;
  localparam logic [AxisW-1:0] AxisTop = 8'd255;
  localparam int HeadNorth = 0;
  localparam int HeadEast = 90;
  localparam int HeadSouth = 180;
  localparam int HeadWest = 270;
  localparam int RightAngle = 90;
  localparam int RootTopBit = 8;
  localparam longint AtanStep [CordSteps] = '{
    2949207, 1741019, 919906, 466959, 234386, 117307, 58668, 29336,
    14668, 7334, 3667, 1834, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic [DirW-1:0] direction;
  } spring_force_t;

  logic clk;
  logic rst_n;

  jsfp_evt_if evt_bus ();
  jsfp_res_if res_bus ();
  jsfp_cfg_if cfg_bus ();

  joystick_spring_force_polar uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .evt_i (evt_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  // predicted stick state and settings
  logic [DzW-1:0]   dz_cfg;
  logic [GainW-1:0] gain_x_cfg;
  logic [GainW-1:0] gain_y_cfg;
  int x_lvl, y_lvl, x_sgn, y_sgn;

  spring_force_t pending_forces[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sink_hold = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic longint trunc_shift(input longint v, input int s);
    if (v < 0) return -((-v) >> s);
    return v >> s;
  endfunction

  function automatic int deflection_angle(input longint unsigned a, input longint unsigned b);
    longint rx, ry, nx, ny, z;
    z = 0;
    if (a == 0) return 0;
    if (b == 0) return RightAngle;
    rx = longint'(b << FracW);
    ry = longint'(a << FracW);
    for (int i = 0; i < CordSteps; i++) begin
      if (ry == 0) break;
      if (ry > 0) begin
        nx = rx + trunc_shift(ry, i);
        ny = ry - trunc_shift(rx, i);
        z = z + AtanStep[i];
      end else begin
        nx = rx - trunc_shift(ry, i);
        ny = ry + trunc_shift(rx, i);
        z = z - AtanStep[i];
      end
      rx = nx;
      ry = ny;
    end
    if (z <= 0) return 0;
    z = z >> FracW;
    return (z > RightAngle) ? RightAngle : int'(z);
  endfunction

  function automatic int force_root(input longint unsigned n);
    longint unsigned m, c;
    m = 0;
    for (int b = RootTopBit; b >= 0; b--) begin
      c = m | (64'd1 << b);
      if (((c * c) << NormShr) <= n) m = c;
    end
    return int'(m);
  endfunction

  function automatic bit predict_force(input logic [AxisW-1:0] axis,
                                       input logic [PosW-1:0] position,
                                       output spring_force_t f);
    int p, dz, t, heading;
    longint unsigned fx, fy;
    p = int'($signed(position));
    dz = int'(dz_cfg);
    f = '0;
    if (axis == AxisX) begin
      if (p < -dz) begin
        x_sgn = -1;
        x_lvl = p;
      end else if (p > dz) begin
        x_sgn = 1;
        x_lvl = p;
      end else begin
        x_sgn = 0;
        x_lvl = 0;
      end
    end else if (axis == AxisY) begin
      if (p < -dz) begin
        y_sgn = 1;
        y_lvl = -p;
      end else if (p > dz) begin
        y_sgn = -1;
        y_lvl = -p;
      end else begin
        y_sgn = 0;
        y_lvl = 0;
      end
    end
    if (x_sgn == 0 && y_sgn == 0) return 1'b0;
    fx = longint'(gain_x_cfg) * longint'(x_lvl < 0 ? -x_lvl : x_lvl);
    fy = longint'(gain_y_cfg) * longint'(y_lvl < 0 ? -y_lvl : y_lvl);
    if (x_sgn == 0) begin
      heading = (y_sgn > 0) ? HeadNorth : HeadSouth;
    end else if (y_sgn == 0) begin
      heading = (x_sgn > 0) ? HeadEast : HeadWest;
    end else begin
      t = deflection_angle(fy, fx);
      if ((x_lvl < 0) != (y_lvl < 0)) t = -t;
      heading = ((x_sgn > 0) ? HeadEast : HeadWest) - t;
    end
    f.magnitude = MagW'(force_root(fx * fx + fy * fy));
    f.direction = DirW'(heading);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_forces.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: magnitude %0d direction %0d",
                                  res_bus.magnitude, res_bus.direction));
      end else begin
        if (pending_forces[0].magnitude !== res_bus.magnitude)
          report_mismatch($sformatf("magnitude expected %0d got %0d",
                                    pending_forces[0].magnitude, res_bus.magnitude));
        if (pending_forces[0].direction !== res_bus.direction)
          report_mismatch($sformatf("direction expected %0d got %0d",
                                    pending_forces[0].direction, res_bus.direction));
        void'(pending_forces.pop_front());
      end
    end
  end

  // result sink with per-transaction stalls and an optional long hold
  initial begin : result_sink
    int pause;
    res_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    res_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        res_bus.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
        res_bus.ready <= 1'b1;
      end else if (res_bus.valid && res_bus.ready) begin
        pause = draw_gap();
        if (pause > 0) begin
          res_bus.ready <= 1'b0;
          repeat (pause) @(posedge clk);
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("joystick_spring_force_polar_tb failed");
    $finish;
  end

  task automatic send_event(input logic [AxisW-1:0] axis, input int position);
    int gap;
    logic [PosW-1:0] raw;
    spring_force_t f;
    raw = PosW'(position);
    gap = draw_gap();
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.axis <= axis;
    evt_bus.position <= raw;
    do @(posedge clk); while (!evt_bus.ready);
    if (predict_force(axis, raw, f)) pending_forces.push_back(f);
  endtask

  task automatic wait_idle();
    evt_bus.valid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] word);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= word;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_DEAD_ZONE: dz_cfg = word[DzW-1:0];
      REG_GAIN_X:    gain_x_cfg = word[GainW-1:0];
      REG_GAIN_Y:    gain_y_cfg = word[GainW-1:0];
      default:       ;
    endcase
  endtask

  // unused upper data bits carry noise
  task automatic load_settings(input int dz, input int gx, input int gy);
    write_reg(REG_DEAD_ZONE, {(CfgDataW - DzW)'($urandom), DzW'(dz)});
    write_reg(REG_GAIN_X, {(CfgDataW - GainW)'($urandom), GainW'(gx)});
    write_reg(REG_GAIN_Y, {(CfgDataW - GainW)'($urandom), GainW'(gy)});
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [AxisW-1:0] pick_axis();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return AxisX;
    if (r < 17) return AxisY;
    return AxisW'($urandom_range(0, 255));
  endfunction

  function automatic int pick_position();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2: begin
        v = int'(dz_cfg) - 1 + $urandom_range(0, 2);
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1)) v = -v - $urandom_range(0, 1);
      end
      default: v = int'($signed(PosW'($urandom)));
    endcase
    return v;
  endfunction

  task automatic test_reset_settings();
    send_event(AxisSpare, 12345);
    send_event(AxisX, 32767);
    send_event(AxisX, -32768);
    send_event(AxisX, 8000);
    send_event(AxisX, -8000);
    send_event(AxisX, 8001);
    send_event(AxisY, -32768);
    send_event(AxisTop, 0);
    send_event(AxisY, 32767);
    send_event(AxisX, -8001);
    send_event(AxisY, -9000);
    send_event(AxisX, 0);
    send_event(AxisY, 8001);
    send_event(AxisY, 0);
    wait_idle();
  endtask

  task automatic test_gain_and_zone_corners();
    // no y gain: angle term vanishes
    load_settings(8000, 10, 0);
    send_event(AxisX, 20000);
    send_event(AxisY, -20000);
    wait_idle();
    // no x gain: angle saturates at a right angle
    load_settings(8000, 0, 10);
    send_event(AxisSpare, 1);
    send_event(AxisY, 20000);
    wait_idle();
    load_settings(8000, 0, 0);
    send_event(AxisX, -20000);
    wait_idle();
    load_settings(0, 255, 255);
    send_event(AxisX, 0);
    send_event(AxisX, 1);
    send_event(AxisY, -1);
    send_event(AxisX, -32768);
    send_event(AxisY, 32767);
    wait_idle();
    load_settings(32767, 1, 255);
    send_event(AxisX, 32767);
    send_event(AxisY, 32767);
    send_event(AxisX, -32768);
    send_event(AxisY, -32768);
    wait_idle();
  endtask

  task automatic test_random_events();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(0, 255, 255);
        1: load_settings(32767, 1, 1);
        2: load_settings(8000, 10, 10);
        default: load_settings($urandom_range(0, 32767) >> $urandom_range(0, 5),
                               $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_event(pick_axis(), pick_position());
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    int mag;
    load_settings(1000, 200, 150);
    no_idle = 1'b1;
    sink_hold = 300;
    for (int n = 0; n < 30; n++) begin
      mag = $urandom_range(2000, 32767);
      send_event((n % 2 == 0) ? AxisX : AxisY, $urandom_range(0, 1) ? mag : -mag);
    end
    no_idle = 1'b0;
    for (int n = 0; n < 120; n++) send_event(pick_axis(), pick_position());
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    evt_bus.valid <= 1'b0;
    evt_bus.axis <= '0;
    evt_bus.position <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_DEAD_ZONE;
    cfg_bus.data <= '0;
    dz_cfg = DzW'(8000);
    gain_x_cfg = GainW'(10);
    gain_y_cfg = GainW'(10);
    x_lvl = 0;
    y_lvl = 0;
    x_sgn = 0;
    y_sgn = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_gain_and_zone_corners();
    test_random_events();
    test_output_backpressure();
    if (mismatch_count == 0 && pending_forces.size() == 0) begin
      $display("joystick_spring_force_polar_tb passed");
    end else begin
      $display("joystick_spring_force_polar_tb failed");
    end
    $finish;
  end

endmodule

FILE: joystick_spring_force_polar.f
rtl/jsfp_pkg.sv
rtl/jsfp_if.sv
rtl/joystick_spring_force_polar.sv
rtl/jsfp_checker.sv
tb/joystick_spring_force_polar_tb.sv
